// ----- sv/ffha_pkg.sv -----
// ============================================================================
// ffha_pkg - shared definitions for the first-fit heap allocator
// Unit geometry, field widths, status codes, transaction payload types and
// the sequencer state encoding.
// ============================================================================
`default_nettype none

package ffha_pkg;

  // Heap geometry. The unit size is a power of two so that byte offsets and
  // unit indexes convert by shifting.
  localparam int unsigned HEAP_UNITS_DEF = 4096;
  localparam int unsigned UNIT_BYTES     = 8;
  localparam int unsigned UB_SHIFT       = $clog2(UNIT_BYTES);

  // Field widths.
  localparam int unsigned REQ_W    = 16;
  localparam int unsigned ADDR_W   = 15;
  localparam int unsigned USED_W   = 16;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned NEED_W   = REQ_W - UB_SHIFT + 1;
  localparam int unsigned MINU_W   = CFG_W - UB_SHIFT + 1;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  // Operation codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_NO_FIT  = 2'd2,
    ST_CORRUPT = 2'd3
  } status_t;

  typedef logic [CFG_W-1:0] cfg_data_t;

  typedef struct packed {
    logic              func;
    logic [REQ_W-1:0]  req_bytes;
    logic [ADDR_W-1:0] block_addr;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] payload_addr;
    logic [USED_W-1:0] used_bytes;
  } rsp_t;

  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_WALK,
    CS_ALLOC_WR,
    CS_FREE_HD,
    CS_MERGE,
    CS_FREE_WR,
    CS_RESP
  } ctrl_state_t;

endpackage

`default_nettype wire

// ----- sv/ffha_chan_if.sv -----
// ============================================================================
// ffha_chan_if - valid/ready channel
// Carries one payload per transaction; the payload type is set where the
// channel is instantiated.
// ============================================================================
`default_nettype none

interface ffha_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ----- sv/ffha_mem.sv -----
// ============================================================================
// ffha_mem - header store
// Single-clock memory with one write port and one read port; the read data
// is registered.
// ============================================================================
`default_nettype none

module ffha_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 14,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output      logic [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/ffha_ctrl.sv -----
// ============================================================================
// ffha_ctrl - allocator sequencer
// Clears the header store after reset, walks headers for allocate, merges
// following free blocks for free, and keeps the running byte total.
// ============================================================================
`default_nettype none

module ffha_ctrl import ffha_pkg::*; #(
  parameter int unsigned HEAP_UNITS = HEAP_UNITS_DEF,
  localparam int unsigned PW = $clog2(HEAP_UNITS),
  localparam int unsigned SW = PW + 1,
  localparam int unsigned HW = SW + 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output      logic             req_ready,
  input  wire req_t             req_data,
  input  wire logic [CFG_W-1:0] min_block_bytes,
  output      logic             res_valid,
  input  wire logic             res_ready,
  output      rsp_t             res_data,
  output      logic             mem_rd_en,
  output      logic [PW-1:0]    mem_rd_addr,
  input  wire logic [HW-1:0]    mem_rd_data,
  output      logic             mem_wr_en,
  output      logic [PW-1:0]    mem_wr_addr,
  output      logic [HW-1:0]    mem_wr_data
);

  localparam int unsigned CMP_W = (NEED_W > SW) ? NEED_W : SW;
  localparam int unsigned UBW   = ADDR_W - UB_SHIFT;
  localparam int unsigned FCW   = (UBW > SW) ? UBW : SW;
  localparam int unsigned CW    = (SW > MINU_W) ? SW : MINU_W;
  localparam int unsigned TB_W  = SW + UB_SHIFT;
  localparam int unsigned SUM_W = ((TB_W > USED_W) ? TB_W : USED_W) + 1;
  localparam int unsigned AW    = ((PW + 1 + UB_SHIFT) > ADDR_W) ? (PW + 1 + UB_SHIFT) : ADDR_W;

  ctrl_state_t       state, state_next;
  logic [PW-1:0]     clr_addr, clr_addr_next;
  logic [PW-1:0]     pos, pos_next;
  logic [PW-1:0]     mptr, mptr_next;
  logic [SW-1:0]     need, need_next;
  logic [MINU_W-1:0] minu, minu_next;
  logic [SW-1:0]     acc, acc_next;
  logic [USED_W-1:0] used_total, used_total_next;
  status_t           status_r, status_next;
  logic [ADDR_W-1:0] addr_r, addr_next;

  // Request decode at acceptance.
  logic [REQ_W:0]    need_sum;
  logic [NEED_W-1:0] need_raw, need_eff;
  logic [CFG_W:0]    min_sum;
  logic [MINU_W-1:0] minu_raw, minu_eff;
  logic              too_big;
  logic [UBW-1:0]    ub;
  logic              free_bad;
  logic [FCW-1:0]    free_pos_full;
  logic [PW-1:0]     free_pos;

  // Header just read.
  logic              rd_used;
  logic [SW-1:0]     rd_size;
  logic [SW:0]       walk_nxt;
  logic              nxt_in;
  logic [SW-1:0]     rem;
  logic              fit, split;
  logic [SW-1:0]     rest_sum;
  logic [SW-1:0]     taken;
  logic [SUM_W-1:0]  add_sum, sub_bytes;
  logic [USED_W-1:0] add_sat, sub_res;
  logic [PW:0]       pos_inc;
  logic [AW-1:0]     pay_full;
  logic [SW-1:0]     acc_new;
  logic [SW:0]       merge_sum;
  logic              merge_in;

  assign need_sum = {1'b0, req_data.req_bytes} + (REQ_W+1)'(2*UNIT_BYTES - 1);
  assign need_raw = need_sum[REQ_W:UB_SHIFT];
  assign min_sum  = {1'b0, min_block_bytes} + (CFG_W+1)'(UNIT_BYTES - 1);
  assign minu_raw = min_sum[CFG_W:UB_SHIFT];
  assign minu_eff = (minu_raw == '0) ? MINU_W'(1) : minu_raw;
  assign need_eff = (NEED_W'(minu_eff) > need_raw) ? NEED_W'(minu_eff) : need_raw;
  assign too_big  = CMP_W'(need_eff) > CMP_W'(HEAP_UNITS);

  // The header sits one unit below the payload offset.
  assign ub            = req_data.block_addr[ADDR_W-1:UB_SHIFT];
  assign free_bad      = (ub == '0) || (FCW'(ub) > FCW'(HEAP_UNITS));
  assign free_pos_full = FCW'(ub) - FCW'(1);
  assign free_pos      = free_pos_full[PW-1:0];

  assign rd_used  = mem_rd_data[SW];
  assign rd_size  = mem_rd_data[SW-1:0];
  assign walk_nxt = {2'b00, pos} + {1'b0, rd_size};
  assign nxt_in   = walk_nxt < (SW+1)'(HEAP_UNITS);
  assign rem      = rd_size - need;
  assign fit      = !rd_used && (rd_size >= need);
  assign split    = CW'(rem) >= CW'(minu);
  assign rest_sum = {1'b0, pos} + need;
  assign taken    = split ? need : rd_size;

  assign add_sum = SUM_W'(used_total) + SUM_W'({taken, {UB_SHIFT{1'b0}}});
  assign add_sat = (add_sum > SUM_W'({USED_W{1'b1}})) ? {USED_W{1'b1}} : add_sum[USED_W-1:0];
  assign sub_bytes = SUM_W'({rd_size, {UB_SHIFT{1'b0}}});
  assign sub_res   = (sub_bytes > SUM_W'(used_total)) ? '0 :
                     USED_W'(SUM_W'(used_total) - sub_bytes);

  assign pos_inc  = {1'b0, pos} + (PW+1)'(1);
  assign pay_full = AW'({pos_inc, {UB_SHIFT{1'b0}}});

  assign acc_new   = acc + rd_size;
  assign merge_sum = {2'b00, pos} + {1'b0, acc_new};
  assign merge_in  = merge_sum < (SW+1)'(HEAP_UNITS);

  assign res_data = '{status: status_r, payload_addr: addr_r, used_bytes: used_total};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CS_CLEAR;
      clr_addr   <= '0;
      used_total <= '0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      used_total <= used_total_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    mptr     <= mptr_next;
    need     <= need_next;
    minu     <= minu_next;
    acc      <= acc_next;
    status_r <= status_next;
    addr_r   <= addr_next;
  end

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    pos_next        = pos;
    mptr_next       = mptr;
    need_next       = need;
    minu_next       = minu;
    acc_next        = acc;
    used_total_next = used_total;
    status_next     = status_r;
    addr_next       = addr_r;
    req_ready       = 1'b0;
    res_valid       = 1'b0;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = pos;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = pos;
    mem_wr_data     = '0;

    case (state)
      CS_CLEAR: begin
        // Entry 0 becomes one free block spanning the heap.
        mem_wr_en     = 1'b1;
        mem_wr_addr   = clr_addr;
        mem_wr_data   = (clr_addr == '0) ? {1'b0, SW'(HEAP_UNITS)} : '0;
        clr_addr_next = clr_addr + PW'(1);
        if (clr_addr == PW'(HEAP_UNITS - 1)) begin
          state_next = CS_IDLE;
        end
      end

      CS_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          addr_next = '0;
          if (req_data.func == FUNC_ALLOC) begin
            if (req_data.req_bytes == '0) begin
              status_next = ST_IGNORED;
              state_next  = CS_RESP;
            end else if (too_big) begin
              status_next = ST_NO_FIT;
              state_next  = CS_RESP;
            end else begin
              need_next   = SW'(need_eff);
              minu_next   = minu_eff;
              pos_next    = '0;
              mem_rd_en   = 1'b1;
              mem_rd_addr = '0;
              state_next  = CS_WALK;
            end
          end else begin
            if (free_bad) begin
              status_next = ST_IGNORED;
              state_next  = CS_RESP;
            end else begin
              pos_next    = free_pos;
              mem_rd_en   = 1'b1;
              mem_rd_addr = free_pos;
              state_next  = CS_FREE_HD;
            end
          end
        end
      end

      CS_WALK: begin
        if (rd_size == '0) begin
          status_next = ST_CORRUPT;
          state_next  = CS_RESP;
        end else if (fit) begin
          status_next     = ST_DONE;
          addr_next       = pay_full[ADDR_W-1:0];
          used_total_next = add_sat;
          mem_wr_en       = 1'b1;
          if (split) begin
            mem_wr_addr = rest_sum[PW-1:0];
            mem_wr_data = {1'b0, rem};
            state_next  = CS_ALLOC_WR;
          end else begin
            mem_wr_addr = pos;
            mem_wr_data = {1'b1, rd_size};
            state_next  = CS_RESP;
          end
        end else if (nxt_in) begin
          pos_next    = walk_nxt[PW-1:0];
          mem_rd_en   = 1'b1;
          mem_rd_addr = walk_nxt[PW-1:0];
        end else begin
          status_next = ST_NO_FIT;
          state_next  = CS_RESP;
        end
      end

      CS_ALLOC_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pos;
        mem_wr_data = {1'b1, need};
        state_next  = CS_RESP;
      end

      CS_FREE_HD: begin
        if (rd_size == '0) begin
          status_next = ST_CORRUPT;
          state_next  = CS_RESP;
        end else begin
          if (rd_used) begin
            used_total_next = sub_res;
          end
          acc_next = rd_size;
          if (nxt_in) begin
            mptr_next   = walk_nxt[PW-1:0];
            mem_rd_en   = 1'b1;
            mem_rd_addr = walk_nxt[PW-1:0];
            state_next  = CS_MERGE;
          end else begin
            state_next = CS_FREE_WR;
          end
        end
      end

      CS_MERGE: begin
        if (!rd_used && (rd_size != '0)) begin
          // Absorb the following block and clear its header.
          mem_wr_en   = 1'b1;
          mem_wr_addr = mptr;
          mem_wr_data = '0;
          acc_next    = acc_new;
          if (merge_in) begin
            mptr_next   = merge_sum[PW-1:0];
            mem_rd_en   = 1'b1;
            mem_rd_addr = merge_sum[PW-1:0];
          end else begin
            state_next = CS_FREE_WR;
          end
        end else begin
          state_next = CS_FREE_WR;
        end
      end

      CS_FREE_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pos;
        mem_wr_data = {1'b0, acc};
        status_next = ST_DONE;
        state_next  = CS_RESP;
      end

      CS_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = CS_IDLE;
        end
      end

      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/first_fit_heap_allocator_core.sv -----
// ============================================================================
// first_fit_heap_allocator_core - first-fit allocator over a unit heap
// Header store, sequencer, configuration register and result register.
// ============================================================================
// An allocate walks the headers from unit 0, with an extra write step when
// the chosen block is split; a free reads its header and then the headers
// behind it. One request is worked at a time, one header read per cycle.
// Reset: synchronous; afterwards a clearing pass over all HEAP_UNITS entries
// (4096 by default) initialises the header store before the first request
// is taken.
`default_nettype none

module first_fit_heap_allocator_core import ffha_pkg::*; #(
  parameter int unsigned HEAP_UNITS = HEAP_UNITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  ffha_chan_if.sink   req,
  ffha_chan_if.source rsp,
  ffha_chan_if.sink   cfg
);

  localparam int unsigned PW = $clog2(HEAP_UNITS);
  localparam int unsigned HW = PW + 2;

  // The minimum block size register; always ready. The user must send writes
  // only while the allocator is idle; the block does not enforce this.
  logic [CFG_W-1:0] min_block_bytes;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_block_bytes <= CFG_RESET;
    end else if (cfg.valid && cfg.ready) begin
      min_block_bytes <= cfg.data;
    end
  end

  // Header store interface. Each entry holds a used mark above a size in
  // units; only entries at block starts are non-zero.
  logic          mem_rd_en;
  logic [PW-1:0] mem_rd_addr;
  logic [HW-1:0] mem_rd_data;
  logic          mem_wr_en;
  logic [PW-1:0] mem_wr_addr;
  logic [HW-1:0] mem_wr_data;

  ffha_mem #(
    .DEPTH (HEAP_UNITS),
    .WIDTH (HW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // The sequencer hands over each finished result to the result register
  // below; it may meanwhile accept and start the next request.
  logic res_valid;
  logic res_ready;
  rsp_t res_data;

  ffha_ctrl #(
    .HEAP_UNITS (HEAP_UNITS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_data        (req.data),
    .min_block_bytes (min_block_bytes),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res_data        (res_data),
    .mem_rd_en       (mem_rd_en),
    .mem_rd_addr     (mem_rd_addr),
    .mem_rd_data     (mem_rd_data),
    .mem_wr_en       (mem_wr_en),
    .mem_wr_addr     (mem_wr_addr),
    .mem_wr_data     (mem_wr_data)
  );

  // Result register: it is loaded when empty or when its transaction
  // completes in the same cycle; a result left waiting holds back the sequencer.
  logic out_valid;
  rsp_t out_data;

  assign res_ready = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res_data;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ffha_checker.sv -----
// ============================================================================
// ffha_checker - port-level checks for the allocator
// Watches the request and result channels and is bound to the top level.
// ============================================================================
`default_nettype none

module ffha_checker import ffha_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp_data
);

  // A result waiting to be taken stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn before it was taken");

  // A stalled result keeps its payload.
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_data))
    else $error("stalled result payload changed");

  // Requests are worked one at a time: no request is taken straight after
  // another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while the previous one was in progress");

  // Only a successful request reports an address.
  a_addr_on_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status != ST_DONE) |-> rsp_data.payload_addr == '0)
    else $error("address reported on an unsuccessful request");

  // Payload addresses sit on unit boundaries.
  a_addr_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.payload_addr[UB_SHIFT-1:0] == '0)
    else $error("payload address not aligned to a unit");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top - testbench for first_fit_heap_allocator_core
// The requests sent to the allocator are mirrored by a shadow heap, which
// works out the status, payload offset and running total that each request
// should return. Every response is compared field by field with the oldest
// outstanding prediction. Both channel ends idle at random, and the minimum
// block size is changed between phases, through its smallest and largest
// values.
// ============================================================================

module tb_top;
  import ffha_pkg::*;

  localparam int unsigned HEAP_UNITS   = HEAP_UNITS_DEF;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned N_PHASES     = 10;
  // A cap on live blocks keeps the header walk, and so the run, short.
  localparam int unsigned LIVE_CAP     = 48;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  // The longest quiet spell in a correct run is the clearing pass after
  // reset, well under this limit.
  localparam int unsigned STALL_LIMIT  = 20000;

  // --------------------------------------------------------------------------
  // Shadow heap: it holds its own copy of the block headers, the used total
  // and the minimum block size, and queues the response that each accepted
  // request should produce.
  // --------------------------------------------------------------------------
  class heap_scoreboard;
    cfg_data_t   min_block_bytes;
    int unsigned blk_size [HEAP_UNITS];
    bit          blk_used [HEAP_UNITS];
    int unsigned used_total;
    rsp_t        due_rsp [$];
    int unsigned live_addrs [$];
    int unsigned errors;

    function new();
      foreach (blk_size[i]) begin
        blk_size[i] = 0;
        blk_used[i] = 1'b0;
      end
      blk_size[0]     = HEAP_UNITS;
      used_total      = 0;
      min_block_bytes = CFG_RESET;
      errors          = 0;
    endfunction

    function void set_min_block(cfg_data_t v);
      min_block_bytes = v;
    endfunction

    // First-fit search from unit 0. The request grows by one header unit,
    // is rounded up to whole units and raised to the minimum block.
    function status_t first_fit(int unsigned req_bytes, output int unsigned payload);
      int unsigned need;
      int unsigned minu;
      int unsigned pos;
      int unsigned s;
      int unsigned taken;
      payload = 0;
      need = (req_bytes + UNIT_BYTES + UNIT_BYTES - 1) / UNIT_BYTES;
      minu = (min_block_bytes + UNIT_BYTES - 1) / UNIT_BYTES;
      if (minu < 1) minu = 1;
      if (need < minu) need = minu;
      if (need > HEAP_UNITS) return ST_NO_FIT;
      pos = 0;
      while (pos < HEAP_UNITS) begin
        s = blk_size[pos];
        if (s == 0) return ST_CORRUPT;
        if (!blk_used[pos] && s >= need) begin
          // A remainder smaller than the minimum stays inside the block
          // and is counted as taken.
          taken = s;
          if (s - need >= minu) begin
            blk_size[pos + need] = s - need;
            blk_used[pos + need] = 1'b0;
            blk_size[pos]        = need;
            taken                = need;
          end
          blk_used[pos] = 1'b1;
          used_total    = used_total + taken * UNIT_BYTES;
          if (used_total > 32'hFFFF) used_total = 32'hFFFF;
          payload = ((pos + 1) * UNIT_BYTES) & 32'h7FFF;
          live_addrs.push_back(payload);
          return ST_DONE;
        end
        pos += s;
      end
      return ST_NO_FIT;
    endfunction

    // Release the block whose payload starts at addr and fold every free
    // block directly behind it into it.
    function status_t release_block(int unsigned addr);
      int unsigned pos;
      int unsigned nxt;
      int unsigned bytes;
      if (addr < UNIT_BYTES) return ST_IGNORED;
      pos = addr / UNIT_BYTES - 1;
      if (pos >= HEAP_UNITS) return ST_IGNORED;
      if (blk_size[pos] == 0) return ST_CORRUPT;
      if (blk_used[pos]) begin
        bytes      = blk_size[pos] * UNIT_BYTES;
        used_total = (bytes > used_total) ? 0 : used_total - bytes;
      end
      blk_used[pos] = 1'b0;
      nxt = pos + blk_size[pos];
      while (nxt < HEAP_UNITS && !blk_used[nxt] && blk_size[nxt] != 0) begin
        blk_size[pos] += blk_size[nxt];
        blk_size[nxt] = 0;
        nxt = pos + blk_size[pos];
      end
      for (int i = live_addrs.size() - 1; i >= 0; i--) begin
        if (live_addrs[i] / UNIT_BYTES - 1 == pos) live_addrs.delete(i);
      end
      return ST_DONE;
    endfunction

    function void log_request(req_t r);
      rsp_t        exp;
      int unsigned payload;
      payload = 0;
      if (r.func == FUNC_ALLOC) begin
        if (r.req_bytes == 0) exp.status = ST_IGNORED;
        else exp.status = first_fit(32'(r.req_bytes), payload);
      end else begin
        if (r.block_addr == 0) exp.status = ST_IGNORED;
        else exp.status = release_block(32'(r.block_addr));
      end
      exp.payload_addr = payload[ADDR_W-1:0];
      exp.used_bytes   = used_total[USED_W-1:0];
      due_rsp.push_back(exp);
    endfunction

    function void compare_field(string field, logic [31:0] exp, logic [31:0] got);
      if (got !== exp) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp, got);
        errors++;
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (due_rsp.size() == 0) begin
        $display("%0t: unexpected response, status %0d addr %0d used %0d",
                 $time, got.status, got.payload_addr, got.used_bytes);
        errors++;
        return;
      end
      exp = due_rsp.pop_front();
      compare_field("status", 32'(exp.status), 32'(got.status));
      compare_field("payload_addr", 32'(exp.payload_addr), 32'(got.payload_addr));
      compare_field("used_bytes", 32'(exp.used_bytes), 32'(got.used_bytes));
    endfunction

    function int unsigned pending();
      return due_rsp.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels and the block itself.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  ffha_chan_if #(.payload_t(req_t))      req_if ();
  ffha_chan_if #(.payload_t(rsp_t))      rsp_if ();
  ffha_chan_if #(.payload_t(cfg_data_t)) cfg_if ();

  first_fit_heap_allocator_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  heap_scoreboard sb;
  bit             src_burst;
  bit             snk_burst;
  bit             hold_off;
  int unsigned    last_freed;
  int unsigned    stall_cycles;

  // --------------------------------------------------------------------------
  // Request side. The valid line is only lowered when a gap is actually
  // wanted, so that back-to-back transactions never see valid dropped and
  // raised within the same time step.
  // --------------------------------------------------------------------------
  task automatic send_req(req_t r);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk); while (!req_if.ready);
    // The transaction has been accepted at this edge; predict its response
    // straight away so that the next request sees the updated heap.
    sb.log_request(r);
    if (r.func == FUNC_FREE) last_freed = 32'(r.block_addr);
    // Now and then switch between idling and running flat out.
    if ($urandom_range(0, 31) == 0) src_burst = !src_burst;
  endtask

  // The field that the operation does not use carries random bits, so that
  // every bit of both fields is exercised.
  function automatic req_t make_req(bit is_free, int unsigned value);
    req_t r;
    r.func       = is_free ? FUNC_FREE : FUNC_ALLOC;
    r.req_bytes  = REQ_W'(is_free ? $urandom : value);
    r.block_addr = ADDR_W'(is_free ? value : $urandom);
    return r;
  endfunction

  // Mostly a healthy mix of allocations and frees of live blocks, with a
  // share of stray addresses, double frees, zero requests and oversize ones.
  function automatic req_t random_req();
    int unsigned pick;
    int unsigned idx;
    pick = $urandom_range(0, 99);
    if (sb.live_addrs.size() != 0 && (sb.live_addrs.size() >= LIVE_CAP || pick < 40)) begin
      idx = $urandom_range(0, sb.live_addrs.size() - 1);
      return make_req(1'b1, sb.live_addrs[idx]);
    end
    if (pick < 44) return make_req(1'b1, $urandom_range(0, 32767));
    if (pick < 47) return make_req(1'b1, last_freed);
    if (pick < 49) return make_req(1'($urandom_range(0, 1)), 0);
    if (pick < 52) return make_req(1'b0, $urandom_range(0, 65535));
    if (pick < 62) return make_req(1'b0, $urandom_range(1, 4096));
    return make_req(1'b0, $urandom_range(1, 256));
  endfunction

  // The minimum block size is only changed with the allocator idle: every
  // outstanding response must have arrived first.
  task automatic write_min_block(cfg_data_t v);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.set_min_block(v);
  endtask

  // --------------------------------------------------------------------------
  // Response side: ready idles at random per transaction, and once holds off
  // for a long stretch so that the allocator backs up and stalls its input.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned wait_cycles;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      wait_cycles = snk_burst ? 0 : $urandom_range(0, 8);
      if (wait_cycles != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      if ($urandom_range(0, 31) == 0) snk_burst = !snk_burst;
    end
  end

  // Every accepted response is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
  end

  // Watchdog: any transaction on any channel counts as progress.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** first_fit_heap_allocator_core: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    // Directed opening, run at the reset minimum of 16 bytes: zero requests,
    // frees below one unit, a request larger than the heap, one allocation of
    // the whole heap followed by a failed one, a free in the middle of a
    // block (zero-size header), double frees, a chain of merges over several
    // free blocks, an unaligned free, a block taken whole because its
    // remainder is under the minimum, and a free near the top of the heap.
    static bit          dir_free [25] = '{0, 1, 1, 1, 0, 0, 0, 1, 0, 0, 1, 1, 1,
                                          0, 0, 0, 1, 1, 1, 1, 0, 0, 1, 0, 1};
    static int unsigned dir_val  [25] = '{0, 0, 5, 7, 65535, 32760, 1, 8, 1, 24, 16, 8, 8,
                                          8, 9, 40, 24, 80, 56, 8, 24, 1, 13, 9, 32767};
    int unsigned n;
    cfg_data_t   v;
    bit          pressure_done;

    sb = new();
    rst          <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= CFG_RESET;
    src_burst     = 1'b0;
    snk_burst     = 1'b0;
    hold_off      = 1'b0;
    last_freed    = 0;
    pressure_done = 1'b0;
    stall_cycles  = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // The allocator runs its clearing pass first; send_req simply waits for
    // ready to rise.
    foreach (dir_free[i]) send_req(make_req(dir_free[i], dir_val[i]));

    // Random phases, each under its own minimum block size. The first few
    // cover the extremes of the register; the rest draw a legal value.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       v = 13'd4096;
        1:       v = 13'd0;
        2:       v = 13'h1FFF;
        3:       v = 13'd24;
        4:       v = 13'd8;
        5:       v = 13'd16;
        default: v = CFG_W'($urandom_range(16, 4096));
      endcase
      write_min_block(v);
      n = 0;
      while (n < RANDOM_ITEMS / N_PHASES) begin
        send_req(random_req());
        // Requests that the allocator merely ignores do not count.
        if (sb.due_rsp[$].status != ST_IGNORED) n++;
        if (ph == 0 && n == 60 && !pressure_done) begin
          hold_off      = 1'b1;
          pressure_done = 1'b1;
        end
      end
    end

    // Drain: wait for the last responses, then a little longer so that a
    // stray extra response would still be caught.
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** first_fit_heap_allocator_core: PASSED **");
    end else begin
      $display("** first_fit_heap_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule
